// ===== sv/atjc_pkg.sv =====
// Shared types, constants and tables for the tilt and stick conditioner.
// Used by every module of the block; depends on nothing.
package atjc_pkg;

    localparam int NUM_CTL_DEF = 2;
    localparam int FRAC_DEF    = 8;
    localparam int QDEPTH      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0] SCRAMBLE = 8'h17;

    localparam logic signed [19:0] PITCH_K   = 20'sd80206;
    localparam logic signed [19:0] ROLL_K    = 20'sd80220;
    localparam logic signed [39:0] ANG_BASE  = 40'sd8257536000;
    localparam logic [18:0]        QSAT_LIM  = 19'd256000;
    localparam logic [18:0]        ANG_RECIP = 19'd268436;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0    = 3'd0,
        CFG_B1    = 3'd1,
        CFG_B2    = 3'd2,
        CFG_A1    = 3'd3,
        CFG_A2    = 3'd4,
        CFG_ZERO  = 3'd5,
        CFG_LIMIT = 3'd6,
        CFG_DZONE = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] b0;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] a1;
        logic signed [15:0] a2;
        logic [9:0]         zero;
        logic [8:0]         limit;
        logic [7:0]         dzone;
    } t_cfg;

    typedef struct packed {
        logic [7:0]         sx;
        logic [7:0]         sy;
        logic               bz;
        logic               bc;
        logic signed [10:0] ax;
        logic signed [10:0] ay;
        logic signed [10:0] az;
        logic               idx;
        logic               present;
    } t_item;

    typedef struct packed {
        logic signed [10:0] x1;
        logic signed [10:0] x2;
        logic signed [19:0] y1;
        logic signed [19:0] y2;
    } t_hist;

    function automatic logic [15:0] atan_coef(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30385;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/accel_tilt_joystick_conditioner_top.sv =====
// Top level of the tilt and stick conditioner: configuration registers and
// the front stage, queue and back stage. Depends on atjc_pkg and its modules.
//
// Each report is decoded by the front stage, registered and queued; the back
// stage then takes it from the queue and works through the filter for each
// accelerometer axis on one shared multiplier, the squares, the bit-serial
// square roots, sixteen CORDIC steps, two scaling multiplies, one reciprocal
// multiply for the quotients and the load of the result register, which waits
// while the previous result has not been taken. Two reports can wait in the
// queue while one is processed. Configuration is accepted on every cycle
// and should be written only while the block is idle.
module accel_tilt_joystick_conditioner_top import atjc_pkg::*; #(
    parameter int NUM_CONTROLLERS = NUM_CTL_DEF,
    parameter int STATE_FRAC_BITS = FRAC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_raw_byte_0,
    input  logic [7:0]            i_raw_byte_1,
    input  logic [7:0]            i_raw_byte_2,
    input  logic [7:0]            i_raw_byte_3,
    input  logic [7:0]            i_raw_byte_4,
    input  logic [7:0]            i_raw_byte_5,
    input  logic                  i_controller_index,
    input  logic                  i_controller_present,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_stick_x_out,
    output logic [7:0]            o_stick_y_out,
    output logic [7:0]            o_pitch_out,
    output logic [7:0]            o_roll_out,
    output logic                  o_button_z_out,
    output logic                  o_button_c_out,
    output logic                  o_source_index,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_f_valid, w_f_ready;
    t_item w_f_item;
    logic  w_q_valid, w_q_pop;
    t_item w_q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.b0    <= 16'sd6066;
            r_cfg.b1    <= 16'sd4044;
            r_cfg.b2    <= 16'sd6066;
            r_cfg.a1    <= -16'sd4700;
            r_cfg.a2    <= 16'sd4491;
            r_cfg.zero  <= 10'd510;
            r_cfg.limit <= 9'd210;
            r_cfg.dzone <= 8'd32;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_B0:    r_cfg.b0    <= i_cfg_data;
                CFG_B1:    r_cfg.b1    <= i_cfg_data;
                CFG_B2:    r_cfg.b2    <= i_cfg_data;
                CFG_A1:    r_cfg.a1    <= i_cfg_data;
                CFG_A2:    r_cfg.a2    <= i_cfg_data;
                CFG_ZERO:  r_cfg.zero  <= i_cfg_data[9:0];
                CFG_LIMIT: r_cfg.limit <= i_cfg_data[8:0];
                CFG_DZONE: r_cfg.dzone <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    atjc_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_in_valid),
        .o_ready              (o_in_ready),
        .i_raw_byte_0         (i_raw_byte_0),
        .i_raw_byte_1         (i_raw_byte_1),
        .i_raw_byte_2         (i_raw_byte_2),
        .i_raw_byte_3         (i_raw_byte_3),
        .i_raw_byte_4         (i_raw_byte_4),
        .i_raw_byte_5         (i_raw_byte_5),
        .i_controller_index   (i_controller_index),
        .i_controller_present (i_controller_present),
        .i_cfg                (r_cfg),
        .o_valid              (w_f_valid),
        .i_ready              (w_f_ready),
        .o_item               (w_f_item)
    );

    atjc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_item  (w_f_item),
        .o_ready (w_f_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    atjc_back #(
        .NUM_CONTROLLERS (NUM_CONTROLLERS),
        .STATE_FRAC_BITS (STATE_FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_stick_x_out  (o_stick_x_out),
        .o_stick_y_out  (o_stick_y_out),
        .o_pitch_out    (o_pitch_out),
        .o_roll_out     (o_roll_out),
        .o_button_z_out (o_button_z_out),
        .o_button_c_out (o_button_c_out),
        .o_source_index (o_source_index)
    );

endmodule

// ===== sv/atjc_front.sv =====
// Front stage: unscrambles a report, scales the stick axes, removes the
// accelerometer offset and registers the decoded item. Depends on atjc_pkg.
module atjc_front import atjc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_raw_byte_0,
    input  logic [7:0] i_raw_byte_1,
    input  logic [7:0] i_raw_byte_2,
    input  logic [7:0] i_raw_byte_3,
    input  logic [7:0] i_raw_byte_4,
    input  logic [7:0] i_raw_byte_5,
    input  logic       i_controller_index,
    input  logic       i_controller_present,
    input  t_cfg       i_cfg,
    output logic       o_valid,
    input  logic       i_ready,
    output t_item      o_item
);

    function automatic logic [7:0] stick_scale(input logic [7:0] v, input logic [7:0] dz);
        logic signed [8:0] s;
        logic [12:0]       p;
        logic [24:0]       q;
        logic [7:0]        r;
        s = $signed({1'b0, v}) - $signed({1'b0, dz});
        p = 13'(s[7:0]) * 13'd27;
        q = (25'(p) * 25'd3277) >> 16;
        if (s <= 9'sd0) begin
            r = 8'd0;
        end else if (q > 25'd255) begin
            r = 8'd255;
        end else begin
            r = q[7:0];
        end
        return r;
    endfunction

    logic [7:0] w_d0, w_d1, w_d2, w_d3, w_d4, w_d5;
    t_item      w_item;
    logic       r_valid;
    t_item      r_item;

    assign w_d0 = (i_raw_byte_0 ^ SCRAMBLE) + SCRAMBLE;
    assign w_d1 = (i_raw_byte_1 ^ SCRAMBLE) + SCRAMBLE;
    assign w_d2 = (i_raw_byte_2 ^ SCRAMBLE) + SCRAMBLE;
    assign w_d3 = (i_raw_byte_3 ^ SCRAMBLE) + SCRAMBLE;
    assign w_d4 = (i_raw_byte_4 ^ SCRAMBLE) + SCRAMBLE;
    assign w_d5 = (i_raw_byte_5 ^ SCRAMBLE) + SCRAMBLE;

    always_comb begin
        w_item.sx      = stick_scale(w_d0, i_cfg.dzone);
        w_item.sy      = stick_scale(~w_d1, i_cfg.dzone);
        w_item.bz      = ~w_d5[0];
        w_item.bc      = ~w_d5[1];
        w_item.ax      = $signed({1'b0, w_d2, w_d5[3:2]}) - $signed({1'b0, i_cfg.zero});
        w_item.ay      = $signed({1'b0, w_d3, w_d5[5:4]}) - $signed({1'b0, i_cfg.zero});
        w_item.az      = $signed({1'b0, w_d4, w_d5[7:6]}) - $signed({1'b0, i_cfg.zero});
        w_item.idx     = i_controller_index;
        w_item.present = i_controller_present;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= w_item;
        end
    end

endmodule

// ===== sv/atjc_fifo.sv =====
// Short queue of decoded items between the front and the back stage.
// Depends on atjc_pkg for the item type and depth.
module atjc_fifo import atjc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QCW-1:0]   r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = r_count != QCW'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== sv/atjc_back.sv =====
// Back stage: per-controller IIR filter, clamp, squares, square roots, CORDIC
// angles, angle scaling and quotients, with the filter, squares and scaling on
// one shared multiplier, plus the result register. Depends on atjc_pkg.
module atjc_back import atjc_pkg::*; #(
    parameter int NUM_CONTROLLERS = NUM_CTL_DEF,
    parameter int STATE_FRAC_BITS = FRAC_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_stick_x_out,
    output logic [7:0] o_stick_y_out,
    output logic [7:0] o_pitch_out,
    output logic [7:0] o_roll_out,
    output logic       o_button_z_out,
    output logic       o_button_c_out,
    output logic       o_source_index
);

    localparam int HN = NUM_CONTROLLERS * 3;
    localparam int AW = $clog2(HN);
    localparam int CW = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;

    localparam logic [4:0] ST_B0   = 5'd0;
    localparam logic [4:0] ST_B1   = 5'd1;
    localparam logic [4:0] ST_B2   = 5'd2;
    localparam logic [4:0] ST_A1   = 5'd3;
    localparam logic [4:0] ST_A2   = 5'd4;
    localparam logic [4:0] ST_UPD  = 5'd5;
    localparam logic [4:0] ST_SQX  = 5'd0;
    localparam logic [4:0] ST_SQZ  = 5'd1;
    localparam logic [4:0] ST_SQY  = 5'd2;
    localparam logic [4:0] ST_SQI  = 5'd3;
    localparam logic [4:0] ST_SQRT_LAST = 5'd19;
    localparam logic [4:0] ST_CORD_LAST = 5'd15;
    localparam logic [4:0] ST_KP   = 5'd0;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_FILT = 8'b0000_0010,
        S_SQ   = 8'b0000_0100,
        S_SQRT = 8'b0000_1000,
        S_CORD = 8'b0001_0000,
        S_KMUL = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state             r_state;
    logic [4:0]         r_step;
    logic [1:0]         r_axis;
    logic               r_out_valid;
    t_hist              r_hist [HN];
    t_item              r_item;
    logic signed [47:0] r_sff, r_sfb;
    logic signed [19:0] r_fx, r_fy, r_fz;
    logic [39:0]        r_sq0, r_sq1;
    logic [39:0]        r_n0, r_n1, r_r0, r_r1;
    logic signed [23:0] r_vx0, r_vy0, r_vx1, r_vy1;
    logic signed [18:0] r_ang0, r_ang1;
    logic               r_pz, r_rz;
    logic [17:0]        r_rem0, r_rem1;
    logic [7:0]         r_q0, r_q1;
    logic [7:0]         r_sx, r_sy, r_pitch, r_roll;
    logic               r_bz, r_bc, r_src;

    logic [CW-1:0]      w_ctl;
    logic [AW-1:0]      w_addr;
    t_hist              w_h;
    logic signed [10:0] w_x0;
    logic signed [19:0] w_ma, w_mb;
    logic signed [39:0] w_prod;
    logic signed [47:0] w_acc, w_yr, w_lim, w_fcl;
    logic signed [19:0] w_ysat;
    logic [39:0]        w_sb, w_t0, w_t1, w_rn0, w_rn1;
    logic               w_ge0, w_ge1;
    logic signed [23:0] w_dx0, w_dy0, w_dx1, w_dy1;
    logic signed [18:0] w_tab;
    logic signed [18:0] w_angp, w_angr;
    logic signed [39:0] w_num;
    logic [18:0]        w_m;
    logic [35:0]        w_qp0, w_qp1;
    logic               w_out_free;
    logic               w_pop;

    assign w_ctl  = (NUM_CONTROLLERS > 1) ? CW'(r_item.idx) : '0;
    assign w_addr = AW'(w_ctl) * AW'(3) + AW'(r_axis);
    assign w_h    = r_hist[w_addr];

    always_comb begin
        case (r_axis)
            2'd0:    w_x0 = r_item.ax;
            2'd1:    w_x0 = r_item.ay;
            default: w_x0 = r_item.az;
        endcase
    end

    assign w_angp = r_pz ? '0 : r_ang0;
    assign w_angr = r_rz ? '0 : r_ang1;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_FILT: begin
                case (r_step)
                    ST_B0: begin
                        w_ma = 20'(i_cfg.b0);
                        w_mb = 20'(w_x0);
                    end
                    ST_B1: begin
                        w_ma = 20'(i_cfg.b1);
                        w_mb = 20'(w_h.x1);
                    end
                    ST_B2: begin
                        w_ma = 20'(i_cfg.b2);
                        w_mb = 20'(w_h.x2);
                    end
                    ST_A1: begin
                        w_ma = 20'(i_cfg.a1);
                        w_mb = w_h.y1;
                    end
                    ST_A2: begin
                        w_ma = 20'(i_cfg.a2);
                        w_mb = w_h.y2;
                    end
                    default: ;
                endcase
            end
            S_SQ: begin
                case (r_step)
                    ST_SQX: begin
                        w_ma = r_fx;
                        w_mb = r_fx;
                    end
                    ST_SQZ: begin
                        w_ma = r_fz;
                        w_mb = r_fz;
                    end
                    ST_SQY: begin
                        w_ma = r_fy;
                        w_mb = r_fy;
                    end
                    default: ;
                endcase
            end
            S_KMUL: begin
                if (r_step == ST_KP) begin
                    w_ma = PITCH_K;
                    w_mb = 20'(w_angp);
                end else begin
                    w_ma = ROLL_K;
                    w_mb = 20'(w_angr);
                end
            end
            default: ;
        endcase
    end

    assign w_prod = w_ma * w_mb;

    assign w_acc  = (r_sff <<< STATE_FRAC_BITS) - r_sfb;
    assign w_yr   = (w_acc + 48'sd8192) >>> 14;
    assign w_lim  = 48'(i_cfg.limit) << STATE_FRAC_BITS;

    always_comb begin
        if (w_yr > 48'sd524287) begin
            w_ysat = 20'sd524287;
        end else if (w_yr < -48'sd524288) begin
            w_ysat = -20'sd524288;
        end else begin
            w_ysat = w_yr[19:0];
        end
        if (48'(w_ysat) > w_lim) begin
            w_fcl = w_lim;
        end else if (48'(w_ysat) < -w_lim) begin
            w_fcl = -w_lim;
        end else begin
            w_fcl = 48'(w_ysat);
        end
    end

    assign w_sb  = 40'd1 << (6'd38 - {r_step, 1'b0});
    assign w_t0  = r_r0 + w_sb;
    assign w_t1  = r_r1 + w_sb;
    assign w_ge0 = r_n0 >= w_t0;
    assign w_ge1 = r_n1 >= w_t1;
    assign w_rn0 = w_ge0 ? ((r_r0 >> 1) + w_sb) : (r_r0 >> 1);
    assign w_rn1 = w_ge1 ? ((r_r1 >> 1) + w_sb) : (r_r1 >> 1);

    assign w_tab = $signed({3'b000, atan_coef(r_step[3:0])});
    assign w_dx0 = r_vy0 >>> r_step[3:0];
    assign w_dy0 = r_vx0 >>> r_step[3:0];
    assign w_dx1 = r_vy1 >>> r_step[3:0];
    assign w_dy1 = r_vx1 >>> r_step[3:0];

    assign w_num = ANG_BASE - w_prod;
    assign w_m   = w_num[34:16];

    // Quotient by 1000 as a reciprocal multiply, exact for remainders below 256000.
    assign w_qp0 = 36'(r_rem0) * 36'(ANG_RECIP);
    assign w_qp1 = 36'(r_rem1) * 36'(ANG_RECIP);

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop    = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < HN; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_FILT;
                        r_step  <= '0;
                        r_axis  <= '0;
                    end
                end
                S_FILT: begin
                    if (r_step == ST_UPD) begin
                        r_hist[w_addr] <= '{x1: w_x0, x2: w_h.x1, y1: w_ysat, y2: w_h.y1};
                        r_step <= '0;
                        if (r_axis == 2'd2) begin
                            r_state <= S_SQ;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                S_SQ: begin
                    if (r_step == ST_SQI) begin
                        r_state <= S_SQRT;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                S_SQRT: begin
                    if (r_step == ST_SQRT_LAST) begin
                        r_state <= S_CORD;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                S_CORD: begin
                    if (r_step == ST_CORD_LAST) begin
                        r_state <= S_KMUL;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                S_KMUL: begin
                    if (r_step == ST_KP) begin
                        r_step <= r_step + 5'd1;
                    end else begin
                        r_state <= S_DIV;
                        r_step  <= '0;
                    end
                end
                S_DIV: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_step  <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_item <= i_q_item;
                end
            end
            S_FILT: begin
                case (r_step)
                    ST_B0: r_sff <= 48'(w_prod);
                    ST_B1, ST_B2: r_sff <= r_sff + 48'(w_prod);
                    ST_A1: r_sfb <= 48'(w_prod);
                    ST_A2: r_sfb <= r_sfb + 48'(w_prod);
                    default: begin
                        case (r_axis)
                            2'd0:    r_fx <= w_fcl[19:0];
                            2'd1:    r_fy <= w_fcl[19:0];
                            default: r_fz <= w_fcl[19:0];
                        endcase
                    end
                endcase
            end
            S_SQ: begin
                case (r_step)
                    ST_SQX: r_sq0 <= w_prod;
                    ST_SQZ: begin
                        r_sq0 <= r_sq0 + w_prod;
                        r_sq1 <= w_prod;
                    end
                    ST_SQY: r_sq1 <= r_sq1 + w_prod;
                    default: begin
                        r_n0 <= r_sq0;
                        r_n1 <= r_sq1;
                        r_r0 <= '0;
                        r_r1 <= '0;
                    end
                endcase
            end
            S_SQRT: begin
                if (w_ge0) begin
                    r_n0 <= r_n0 - w_t0;
                end
                if (w_ge1) begin
                    r_n1 <= r_n1 - w_t1;
                end
                r_r0 <= w_rn0;
                r_r1 <= w_rn1;
                if (r_step == ST_SQRT_LAST) begin
                    r_vx0  <= $signed({4'b0000, w_rn0[19:0]});
                    r_vy0  <= 24'(r_fy);
                    r_vx1  <= $signed({4'b0000, w_rn1[19:0]});
                    r_vy1  <= -24'(r_fx);
                    r_ang0 <= '0;
                    r_ang1 <= '0;
                    r_pz   <= r_fy == '0;
                    r_rz   <= r_fx == '0;
                end
            end
            S_CORD: begin
                if (!r_vy0[23]) begin
                    r_vx0  <= r_vx0 + w_dx0;
                    r_vy0  <= r_vy0 - w_dy0;
                    r_ang0 <= r_ang0 + w_tab;
                end else begin
                    r_vx0  <= r_vx0 - w_dx0;
                    r_vy0  <= r_vy0 + w_dy0;
                    r_ang0 <= r_ang0 - w_tab;
                end
                if (!r_vy1[23]) begin
                    r_vx1  <= r_vx1 + w_dx1;
                    r_vy1  <= r_vy1 - w_dy1;
                    r_ang1 <= r_ang1 + w_tab;
                end else begin
                    r_vx1  <= r_vx1 - w_dx1;
                    r_vy1  <= r_vy1 + w_dy1;
                    r_ang1 <= r_ang1 - w_tab;
                end
            end
            S_KMUL: begin
                if (r_step == ST_KP) begin
                    if (w_num[39]) begin
                        r_rem0 <= '0;
                        r_q0   <= '0;
                    end else if (w_m >= QSAT_LIM) begin
                        r_rem0 <= '0;
                        r_q0   <= 8'd255;
                    end else begin
                        r_rem0 <= w_m[17:0];
                        r_q0   <= '0;
                    end
                end else begin
                    if (w_num[39]) begin
                        r_rem1 <= '0;
                        r_q1   <= '0;
                    end else if (w_m >= QSAT_LIM) begin
                        r_rem1 <= '0;
                        r_q1   <= 8'd255;
                    end else begin
                        r_rem1 <= w_m[17:0];
                        r_q1   <= '0;
                    end
                end
            end
            S_DIV: begin
                r_q0 <= r_q0 | w_qp0[35:28];
                r_q1 <= r_q1 | w_qp1[35:28];
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_src   <= r_item.idx;
                    r_sx    <= r_item.present ? r_item.sx : 8'd0;
                    r_sy    <= r_item.present ? r_item.sy : 8'd0;
                    r_pitch <= r_item.present ? r_q0 : 8'd0;
                    r_roll  <= r_item.present ? r_q1 : 8'd0;
                    r_bz    <= r_item.present && r_item.bz;
                    r_bc    <= r_item.present && r_item.bc;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_stick_x_out  = r_sx;
    assign o_stick_y_out  = r_sy;
    assign o_pitch_out    = r_pitch;
    assign o_roll_out     = r_roll;
    assign o_button_z_out = r_bz;
    assign o_button_c_out = r_bc;
    assign o_source_index = r_src;

    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_step == '0))
        else $error("step counter not cleared in idle");

    a_sqrt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_step <= ST_SQRT_LAST))
        else $error("square root step out of range");

    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not loaded into output register");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_state == S_FILT && r_axis == 2'd0))
        else $error("queue pop did not start the filter");

endmodule
